// ===== src/sorted_insert_priority_queue_assert.svh =====
// Assertion macros for the sorted insert priority queue.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is high.
`define SIPQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sipq assertion failed");

// Clocked check that also holds during reset.
`define SIPQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sipq assertion failed");

`else

`define SIPQ_ASSERT(label, clk, rst, prop)
`define SIPQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== src/sipq_pkg.sv =====
package sipq_pkg;

  // Build defaults
  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 8;

  // Capacity register
  localparam int CAP_WIDTH = 5;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

  // Commands carried on s_tuser
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } command_t;

  // Result status carried on m_tuser
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

// ===== src/sorted_insert_priority_queue.sv =====
// Channel   Dir  Fields (lowest bit first)                       Handshake
// s_*       in   tuser: command; tdata: key                      s_tvalid/s_tready
// m_*       out  tuser: status; tdata: head_key, head_valid,     m_tvalid/m_tready
//                entry_count
// cfg_*     in   cfg_data: capacity                              cfg_valid/cfg_ready
//
// One item at a time; each entry walked takes a registered read, then a compare/move.
// Overflow or empty results skip the walk; every result passes a head read before m_tvalid.
// Synchronous reset empties the queue and sets capacity to 16; no clearing pass.
// s_tready is low while an item is in work; a result held by m_tready stalls the next
// result, not the acceptance of the next item.
`include "sorted_insert_priority_queue_assert.svh"

module sorted_insert_priority_queue #(
  parameter int DEPTH     = sipq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = sipq_pkg::KEY_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input beats
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [((KEY_WIDTH+7)/8)*8-1:0]   s_tdata,   // key
  input  logic                             s_tuser,   // command
  // result beats
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [((KEY_WIDTH+1+$clog2(DEPTH+1)+7)/8)*8-1:0]
                                           m_tdata,   // head_key, head_valid, entry_count
  output logic [1:0]                       m_tuser,   // status
  // capacity register write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sipq_pkg::CAP_WIDTH-1:0]   cfg_data
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > sipq_pkg::CAP_WIDTH) ? CNT_W : sipq_pkg::CAP_WIDTH;
  localparam int OUT_W  = ((KEY_WIDTH + 1 + CNT_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_CMP,
    S_SHF_RD,
    S_SHF_WR,
    S_HEAD_RD,
    S_HEAD_LD
  } state_t;

  state_t                        state;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              idx;
  logic [KEY_WIDTH-1:0]          key_r;
  logic [sipq_pkg::CAP_WIDTH-1:0] capacity;
  sipq_pkg::status_t             status_r;
  sipq_pkg::status_t             status_o;
  logic [KEY_WIDTH-1:0]          head_key;
  logic                          head_valid;
  logic [CNT_W-1:0]              entry_count;

  // key store
  logic [KEY_WIDTH-1:0]          mem [DEPTH];
  logic [KEY_WIDTH-1:0]          rd_data;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;
  logic [KEY_WIDTH-1:0]          wr_data;

  logic [CNT_W-1:0]              idx_m1;
  logic [CNT_W-1:0]              idx_p1;
  logic [CNT_W-1:0]              idx_p2;
  logic [CMP_W-1:0]              cap_ext;
  logic [CMP_W-1:0]              eff_cap;
  logic                          full;
  logic                          key_lt;
  logic                          key_eq;

  assign idx_m1 = idx - CNT_W'(1);
  assign idx_p1 = idx + CNT_W'(1);
  assign idx_p2 = idx + CNT_W'(2);

  // effective capacity: zero counts as one, clipped to the built depth
  assign cap_ext = CMP_W'(capacity);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full = (CMP_W'(count) >= eff_cap);

  // less-than and equality compares of the key under work against the read entry
  assign key_lt = (key_r < rd_data);
  assign key_eq = (key_r == rd_data);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tuser   = status_o;
  assign m_tdata   = OUT_W'({entry_count, head_valid, head_key});

  // memory port control
  always_comb begin
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_data = key_r;
    unique case (state)
      S_INS_RD: rd_addr = idx_m1[AW-1:0];
      S_SHF_RD: rd_addr = idx_p1[AW-1:0];
      S_HEAD_RD,
      S_HEAD_LD: rd_addr = '0;
      S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_data = key_lt ? rd_data : key_r;
      end
      S_INS_PUT: wr_en = 1'b1;
      S_SHF_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      default: rd_addr = idx[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx[AW-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      capacity <= sipq_pkg::CAP_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      // result taken; a pending head load refills it below
      if (m_tvalid && m_tready && state != S_HEAD_LD) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            key_r <= s_tdata[KEY_WIDTH-1:0];
            if (sipq_pkg::command_t'(s_tuser) == sipq_pkg::CMD_INSERT) begin
              if (full) begin
                status_r <= sipq_pkg::ST_OVERFLOW;
                state    <= S_HEAD_RD;
              end else begin
                idx   <= count;
                state <= (count == '0) ? S_INS_PUT : S_INS_RD;
              end
            end else if (count == '0) begin
              status_r <= sipq_pkg::ST_EMPTY;
              state    <= S_HEAD_RD;
            end else begin
              idx   <= '0;
              state <= S_DEL_RD;
            end
          end
        end
        S_INS_RD: state <= S_INS_CMP;
        S_INS_CMP: begin
          // larger entry moved up one slot; otherwise the key landed
          if (key_lt) begin
            idx   <= idx_m1;
            state <= (idx_m1 == '0) ? S_INS_PUT : S_INS_RD;
          end else begin
            count    <= count + CNT_W'(1);
            status_r <= sipq_pkg::ST_DONE;
            state    <= S_HEAD_RD;
          end
        end
        S_INS_PUT: begin
          count    <= count + CNT_W'(1);
          status_r <= sipq_pkg::ST_DONE;
          state    <= S_HEAD_RD;
        end
        S_DEL_RD: state <= S_DEL_CMP;
        S_DEL_CMP: begin
          if (key_eq) begin
            if (idx_p1 < count) begin
              state <= S_SHF_RD;
            end else begin
              count    <= count - CNT_W'(1);
              status_r <= sipq_pkg::ST_DONE;
              state    <= S_HEAD_RD;
            end
          end else if (idx_p1 == count) begin
            status_r <= sipq_pkg::ST_NOT_FOUND;
            state    <= S_HEAD_RD;
          end else begin
            idx   <= idx_p1;
            state <= S_DEL_RD;
          end
        end
        S_SHF_RD: state <= S_SHF_WR;
        S_SHF_WR: begin
          // close the gap one entry at a time
          idx <= idx_p1;
          if (idx_p2 < count) begin
            state <= S_SHF_RD;
          end else begin
            count    <= count - CNT_W'(1);
            status_r <= sipq_pkg::ST_DONE;
            state    <= S_HEAD_RD;
          end
        end
        S_HEAD_RD: state <= S_HEAD_LD;
        S_HEAD_LD: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            status_o    <= status_r;
            head_key    <= (count != '0) ? rd_data : '0;
            head_valid  <= (count != '0);
            entry_count <= count;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `SIPQ_ASSERT(a_count_in_range, clk, rst, count <= CNT_W'(DEPTH))
  `SIPQ_ASSERT(a_busy_after_accept, clk, rst, (s_tvalid && s_tready) |=> (state != S_IDLE))
  `SIPQ_ASSERT(a_head_flag_matches, clk, rst, m_tvalid |-> (head_valid == (entry_count != '0)))
  `SIPQ_ASSERT(a_insert_walk_idx, clk, rst, (state == S_INS_CMP) |-> (idx != '0))
  `SIPQ_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE && !m_tvalid))

endmodule
